// ----- rtl/core/i2cram_pkg.sv -----
// Shared types and constants of the I2C register access master.
package i2cram_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [7:0] READ_BIT = 8'h01;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_SUPPLY = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ADDR_NAK = 2'd1,
    STAT_REG_NAK  = 2'd2,
    STAT_DATA_NAK = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_START      = 4'd1,
    ST_ADDR_W     = 4'd2,
    ST_ACK_ADDR_W = 4'd3,
    ST_REG        = 4'd4,
    ST_ACK_REG    = 4'd5,
    ST_WAIT       = 4'd6,
    ST_WDATA      = 4'd7,
    ST_ACK_DATA   = 4'd8,
    ST_RSTART     = 4'd9,
    ST_ADDR_R     = 4'd10,
    ST_ACK_ADDR_R = 4'd11,
    ST_RDATA      = 4'd12,
    ST_MACK       = 4'd13,
    ST_STOP       = 4'd14
  } stage_t;

  // One classified word as it waits in the queue.
  typedef struct packed {
    cmd_t       op;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic       read_not_write;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

// ----- rtl/core/i2cram_if.sv -----
// Request and response channel interfaces of the I2C register access master.
interface i2cram_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic       read_not_write;
  logic [7:0] byte_count;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, command, dev_addr, reg_addr, read_not_write,
                  byte_count, write_data, sda_in, input ready);
  modport sink (input valid, command, dev_addr, reg_addr, read_not_write,
                byte_count, write_data, sda_in, output ready);
endinterface

interface i2cram_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       need_byte;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_last;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, scl_level, sda_pull_low, busy_res, need_byte,
                  read_valid, read_data, read_last, done_res, status, input ready);
  modport sink (input valid, scl_level, sda_pull_low, busy_res, need_byte,
                read_valid, read_data, read_last, done_res, status, output ready);
endinterface

// ----- rtl/core/i2cram_front.sv -----
// Front end: accepts request words, classifies the command and queues them.
module i2cram_front #(
  parameter int DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  i2cram_req_if.sink               req,
  input  logic                     pop,
  output logic                     q_valid,
  output i2cram_pkg::item_t        q_item,
  output i2cram_pkg::queue_stat_t  q_stat
);
  import i2cram_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          do_pop;
  item_t         incoming;

  always_comb begin
    incoming.op             = cmd_t'(req.command);
    incoming.dev_addr       = req.dev_addr;
    incoming.reg_addr       = req.reg_addr;
    incoming.read_not_write = req.read_not_write;
    incoming.byte_count     = req.byte_count;
    incoming.write_data     = req.write_data;
    incoming.sda_in         = req.sda_in;
  end

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == FULL_CNT);
  assign req.ready    = !q_stat.full;
  assign push         = req.valid && !q_stat.full;
  assign q_valid      = !q_stat.empty;
  assign do_pop       = pop && q_valid;
  assign q_item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/i2cram_back.sv -----
// Back end: bus phase sequencer and the registered response word.
module i2cram_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  i2cram_pkg::item_t  q_item,
  output logic               pop,
  i2cram_rsp_if.source       rsp
);
  import i2cram_pkg::*;

  stage_t     stage, stage_next;
  logic [1:0] phase, phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [6:0] saved_device, saved_device_next;
  logic [7:0] saved_register, saved_register_next;
  logic       saved_direction, saved_direction_next;
  status_t    result_status, result_status_next;
  logic       byte_ready, byte_ready_next;
  logic       line_scl, line_scl_next;
  logic       line_sda, line_sda_next;

  logic       rvalid, rlast, done;
  logic [7:0] rdata;

  // A tick that finds a latched byte in WAIT starts the data byte right away.
  logic       is_tick, launch;
  stage_t     eff_stage;
  logic [1:0] eff_phase;
  logic [2:0] eff_bit;
  logic [7:0] eff_bytes;

  logic take;

  assign take    = q_valid && (!rsp.valid || rsp.ready);
  assign pop     = take;
  assign is_tick = (q_item.op == CMD_TICK);
  assign launch  = is_tick && (stage == ST_WAIT) && byte_ready;

  assign eff_stage = launch ? ST_WDATA : stage;
  assign eff_phase = launch ? 2'd0 : phase;
  assign eff_bit   = launch ? 3'd7 : bit_index;
  assign eff_bytes = launch ? bytes_left - 8'd1 : bytes_left;

  // Next state of the sequencer.
  always_comb begin
    stage_next           = stage;
    phase_next           = phase;
    bit_index_next       = bit_index;
    shift_byte_next      = shift_byte;
    bytes_left_next      = bytes_left;
    saved_device_next    = saved_device;
    saved_register_next  = saved_register;
    saved_direction_next = saved_direction;
    result_status_next   = result_status;
    byte_ready_next      = byte_ready;
    case (q_item.op)
      CMD_BEGIN: begin
        if (stage == ST_IDLE) begin
          saved_device_next    = q_item.dev_addr;
          saved_register_next  = q_item.reg_addr;
          saved_direction_next = q_item.read_not_write;
          bytes_left_next      = q_item.byte_count;
          result_status_next   = STAT_OK;
          byte_ready_next      = 1'b0;
          stage_next           = ST_START;
          phase_next           = 2'd0;
        end
      end
      CMD_SUPPLY: begin
        if (stage == ST_WAIT && !byte_ready) begin
          shift_byte_next = q_item.write_data;
          byte_ready_next = 1'b1;
        end
      end
      CMD_TICK: begin
        if (launch) begin
          byte_ready_next = 1'b0;
        end
        stage_next      = eff_stage;
        phase_next      = eff_phase;
        bit_index_next  = eff_bit;
        bytes_left_next = eff_bytes;
        case (eff_stage)
          ST_IDLE: begin
          end
          ST_START: begin
            if (eff_phase == 2'd0) begin
              phase_next = 2'd1;
            end else begin
              stage_next      = ST_ADDR_W;
              phase_next      = 2'd0;
              shift_byte_next = {saved_device, 1'b0};
              bit_index_next  = 3'd7;
            end
          end
          ST_ADDR_W, ST_REG, ST_WDATA, ST_ADDR_R: begin
            if (eff_phase == 2'd0) begin
              phase_next = 2'd1;
            end else if (eff_phase == 2'd1) begin
              phase_next = 2'd2;
            end else if (eff_bit == 3'd0) begin
              phase_next = 2'd0;
              case (eff_stage)
                ST_ADDR_W: stage_next = ST_ACK_ADDR_W;
                ST_REG:    stage_next = ST_ACK_REG;
                ST_WDATA:  stage_next = ST_ACK_DATA;
                default:   stage_next = ST_ACK_ADDR_R;
              endcase
            end else begin
              bit_index_next = eff_bit - 3'd1;
              phase_next     = 2'd0;
            end
          end
          ST_ACK_ADDR_W, ST_ACK_REG, ST_ACK_DATA, ST_ACK_ADDR_R: begin
            if (eff_phase == 2'd0) begin
              phase_next = 2'd1;
            end else if (eff_phase == 2'd1) begin
              phase_next = 2'd2;
              if (q_item.sda_in) begin
                case (eff_stage)
                  ST_ACK_REG:  result_status_next = STAT_REG_NAK;
                  ST_ACK_DATA: result_status_next = STAT_DATA_NAK;
                  default:     result_status_next = STAT_ADDR_NAK;
                endcase
              end
            end else begin
              phase_next = 2'd0;
              if (result_status != STAT_OK) begin
                stage_next = ST_STOP;
              end else begin
                case (eff_stage)
                  ST_ACK_ADDR_W: begin
                    stage_next      = ST_REG;
                    shift_byte_next = saved_register;
                    bit_index_next  = 3'd7;
                  end
                  ST_ACK_REG: begin
                    if (saved_direction) begin
                      stage_next = ST_RSTART;
                    end else if (eff_bytes == 8'd0) begin
                      stage_next = ST_STOP;
                    end else begin
                      stage_next = ST_WAIT;
                    end
                  end
                  ST_ACK_DATA: begin
                    stage_next = (eff_bytes == 8'd0) ? ST_STOP : ST_WAIT;
                  end
                  default: begin
                    if (eff_bytes == 8'd0) begin
                      stage_next = ST_STOP;
                    end else begin
                      stage_next      = ST_RDATA;
                      shift_byte_next = 8'd0;
                      bit_index_next  = 3'd7;
                    end
                  end
                endcase
              end
            end
          end
          ST_WAIT: begin
          end
          ST_RSTART: begin
            if (eff_phase == 2'd3) begin
              stage_next      = ST_ADDR_R;
              phase_next      = 2'd0;
              shift_byte_next = {saved_device, 1'b0} | READ_BIT;
              bit_index_next  = 3'd7;
            end else begin
              phase_next = eff_phase + 2'd1;
            end
          end
          ST_RDATA: begin
            if (eff_phase == 2'd0) begin
              phase_next = 2'd1;
            end else if (eff_phase == 2'd1) begin
              phase_next      = 2'd2;
              shift_byte_next = {shift_byte[6:0], q_item.sda_in};
              if (eff_bit == 3'd0) begin
                bytes_left_next = eff_bytes - 8'd1;
              end
            end else if (eff_bit == 3'd0) begin
              stage_next = ST_MACK;
              phase_next = 2'd0;
            end else begin
              bit_index_next = eff_bit - 3'd1;
              phase_next     = 2'd0;
            end
          end
          ST_MACK: begin
            if (eff_phase == 2'd0) begin
              phase_next = 2'd1;
            end else if (eff_phase == 2'd1) begin
              phase_next = 2'd2;
            end else begin
              phase_next = 2'd0;
              if (eff_bytes == 8'd0) begin
                stage_next = ST_STOP;
              end else begin
                stage_next      = ST_RDATA;
                shift_byte_next = 8'd0;
                bit_index_next  = 3'd7;
              end
            end
          end
          ST_STOP: begin
            if (eff_phase == 2'd2) begin
              stage_next = ST_IDLE;
              phase_next = 2'd0;
            end else begin
              phase_next = eff_phase + 2'd1;
            end
          end
          default: begin
            stage_next = ST_IDLE;
            phase_next = 2'd0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Line levels and per-phase flags.
  always_comb begin
    line_scl_next = line_scl;
    line_sda_next = line_sda;
    rvalid        = 1'b0;
    rdata         = 8'd0;
    rlast         = 1'b0;
    done          = 1'b0;
    if (is_tick) begin
      case (eff_stage)
        ST_IDLE: begin
          line_scl_next = 1'b1;
          line_sda_next = 1'b0;
        end
        ST_START: begin
          line_scl_next = (eff_phase == 2'd0);
          line_sda_next = 1'b1;
        end
        ST_ADDR_W, ST_REG, ST_WDATA, ST_ADDR_R: begin
          line_sda_next = !shift_byte[eff_bit];
          line_scl_next = (eff_phase == 2'd1);
        end
        ST_ACK_ADDR_W, ST_ACK_REG, ST_ACK_DATA, ST_ACK_ADDR_R: begin
          line_sda_next = 1'b0;
          line_scl_next = (eff_phase == 2'd1);
        end
        ST_WAIT: begin
          line_scl_next = 1'b0;
          line_sda_next = 1'b0;
        end
        ST_RSTART: begin
          line_scl_next = (eff_phase == 2'd1) || (eff_phase == 2'd2);
          line_sda_next = (eff_phase == 2'd2) || (eff_phase == 2'd3);
        end
        ST_RDATA: begin
          line_sda_next = 1'b0;
          line_scl_next = (eff_phase == 2'd1);
          if (eff_phase == 2'd1 && eff_bit == 3'd0) begin
            rvalid = 1'b1;
            rdata  = {shift_byte[6:0], q_item.sda_in};
            rlast  = (eff_bytes == 8'd1);
          end
        end
        ST_MACK: begin
          line_sda_next = (eff_bytes != 8'd0);
          line_scl_next = (eff_phase == 2'd1);
        end
        ST_STOP: begin
          line_scl_next = (eff_phase != 2'd0);
          line_sda_next = (eff_phase != 2'd2);
          done          = (eff_phase == 2'd2);
        end
        default: begin
          line_scl_next = 1'b1;
          line_sda_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage           <= ST_IDLE;
      phase           <= 2'd0;
      bit_index       <= 3'd0;
      shift_byte      <= 8'd0;
      bytes_left      <= 8'd0;
      saved_device    <= 7'd0;
      saved_register  <= 8'd0;
      saved_direction <= 1'b0;
      result_status   <= STAT_OK;
      byte_ready      <= 1'b0;
      line_scl        <= 1'b1;
      line_sda        <= 1'b0;
    end else if (take) begin
      stage           <= stage_next;
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      bytes_left      <= bytes_left_next;
      saved_device    <= saved_device_next;
      saved_register  <= saved_register_next;
      saved_direction <= saved_direction_next;
      result_status   <= result_status_next;
      byte_ready      <= byte_ready_next;
      line_scl        <= line_scl_next;
      line_sda        <= line_sda_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.scl_level    <= line_scl_next;
      rsp.sda_pull_low <= line_sda_next;
      rsp.busy_res     <= (stage_next != ST_IDLE);
      rsp.need_byte    <= (stage_next == ST_WAIT) && !byte_ready_next;
      rsp.read_valid   <= rvalid;
      rsp.read_data    <= rdata;
      rsp.read_last    <= rlast;
      rsp.done_res     <= done;
      rsp.status       <= result_status_next;
    end
  end

endmodule

// ----- rtl/core/i2c_register_access_master_unit.sv -----
// Top level of the I2C register access master: front queue and phase sequencer.
//
//   channel  direction  contents
//   req      in         command, dev_addr, reg_addr, read_not_write, byte_count,
//                       write_data, sda_in
//   rsp      out        scl_level, sda_pull_low, busy_res, need_byte, read_valid,
//                       read_data, read_last, done_res, status
//
// Every request word yields one response word; one word per cycle is sustained while rsp is ready.
// Each word passes through the front queue and then the response register.
// The sequencer state updates once for each word taken from the queue.
// Reset is synchronous and leaves the bus lines released and the queue empty.
// A stalled rsp lets the queue fill (QUEUE_DEPTH words) before req.ready drops.
module i2c_register_access_master_unit #(
  parameter int QUEUE_DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  i2cram_req_if.sink   req,
  i2cram_rsp_if.source rsp
);
  import i2cram_pkg::*;

  logic        q_valid;
  item_t       q_item;
  queue_stat_t q_stat;
  logic        pop;

  i2cram_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .pop     (pop),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_stat  (q_stat)
  );

  i2cram_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .rsp     (rsp)
  );

  // A queued word with a free response register must come out next cycle.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && !rsp.valid) |=> rsp.valid)
    else $error("queued word not moved to response");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.done_res) |-> !rsp.busy_res)
    else $error("stop completed while still busy");

  a_wait_low: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.need_byte) |-> (rsp.busy_res && !rsp.scl_level))
    else $error("waiting for a byte without holding SCL low");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.read_valid) |-> (rsp.scl_level && rsp.status == STAT_OK))
    else $error("read byte outside a healthy sample phase");

endmodule
